/* rtl/core/tap_double_tap_hold_key_detector_top_assert.svh */
// Assertion macros for the tap / double tap / hold key detector.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef TAP_DOUBLE_TAP_HOLD_KEY_DETECTOR_TOP_ASSERT_SVH
`define TAP_DOUBLE_TAP_HOLD_KEY_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TDTHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdthk assertion failed");
`define TDTHK_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tdthk forbidden condition");
`else
`define TDTHK_ASSERT(lbl, clk, rst_n, prop)
`define TDTHK_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/core/tdthk_pkg.sv */
// Shared types and constants for the tap / double tap / hold key detector.
// No dependencies.
`default_nettype none

package tdthk_pkg;

    localparam int unsigned TERM_W = 16;

    localparam logic [TERM_W-1:0] HOLD_TERM_RST = 16'd200;
    localparam logic [TERM_W-1:0] DTAP_TERM_RST = 16'd180;

    typedef enum logic [0:0] {
        CFG_HOLD_TERM = 1'b0,
        CFG_DTAP_TERM = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_PRESSED = 3'b010,
        PH_WAIT    = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_HOLD_ON = 3'd1,
        ACT_HOLD_OFF = 3'd2,
        ACT_TAP     = 3'd3,
        ACT_DOUBLE  = 3'd4
    } action_t;

    typedef struct packed {
        logic mode;
        logic is_dual_key;
        logic pressed;
    } item_t;

    // packed so that action lands in the lowest bits
    typedef struct packed {
        logic    base_is_kana;
        logic    hold_active;
        logic    consumed;
        action_t action;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/tdthk_cfg_regs.sv */
// Configuration registers (hold term, double tap term).
// Depends on tdthk_pkg.
`default_nettype none

module tdthk_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire tdthk_pkg::cfg_idx_t           cfg_addr,
    input  wire logic [tdthk_pkg::TERM_W-1:0]  cfg_wdata,
    output logic      [tdthk_pkg::TERM_W-1:0]  hold_term,
    output logic      [tdthk_pkg::TERM_W-1:0]  dtap_term
);

    logic [tdthk_pkg::TERM_W-1:0] hold_term_reg;
    logic [tdthk_pkg::TERM_W-1:0] dtap_term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_term_reg <= tdthk_pkg::HOLD_TERM_RST;
            dtap_term_reg <= tdthk_pkg::DTAP_TERM_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                tdthk_pkg::CFG_HOLD_TERM: hold_term_reg <= cfg_wdata;
                tdthk_pkg::CFG_DTAP_TERM: dtap_term_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign hold_term = hold_term_reg;
    assign dtap_term = dtap_term_reg;

endmodule

`default_nettype wire

/* rtl/core/tdthk_in_stage.sv */
// Input register stage: captures one transaction, holds it until the core advances.
// Depends on tdthk_pkg.
`default_nettype none

module tdthk_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire tdthk_pkg::item_t s_item,
    input  wire logic             advance,
    output logic                  in_valid,
    output tdthk_pkg::item_t      in_item
);

    logic             in_valid_reg;
    logic             in_valid_next;
    tdthk_pkg::item_t item_reg;
    logic             take;

    // register frees up whenever its content moves on
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= s_item;
    end

    assign in_valid = in_valid_reg;
    assign in_item  = item_reg;

endmodule

`default_nettype wire

/* rtl/core/tdthk_fsm.sv */
// Key classifier state: phase, hold flag, saturating tick counter, base layer.
// Depends on tdthk_pkg and the assertion macro header.
`default_nettype none
`include "tap_double_tap_hold_key_detector_top_assert.svh"

module tdthk_fsm (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire tdthk_pkg::item_t             item,
    input  wire logic [tdthk_pkg::TERM_W-1:0] hold_term,
    input  wire logic [tdthk_pkg::TERM_W-1:0] dtap_term,
    output tdthk_pkg::result_t                result
);

    tdthk_pkg::phase_t            phase_reg, phase_next;
    logic                         hold_reg, hold_next;
    logic [tdthk_pkg::TERM_W-1:0] elapsed_reg, elapsed_next;
    logic                         kana_reg, kana_next;
    logic [tdthk_pkg::TERM_W-1:0] cnt_inc;
    tdthk_pkg::action_t           action;
    logic                         consumed;

    // counter stops at all ones, so a term of all ones never expires
    assign cnt_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        hold_next    = hold_reg;
        elapsed_next = elapsed_reg;
        kana_next    = kana_reg;
        action       = tdthk_pkg::ACT_NONE;
        consumed     = 1'b0;
        if (!item.mode)
        begin
            elapsed_next = cnt_inc;
            if (phase_reg == tdthk_pkg::PH_PRESSED && !hold_reg && cnt_inc > hold_term)
            begin
                hold_next = 1'b1;
                action    = tdthk_pkg::ACT_HOLD_ON;
            end
            else if (phase_reg == tdthk_pkg::PH_WAIT && cnt_inc > dtap_term)
            begin
                phase_next = tdthk_pkg::PH_IDLE;
                kana_next  = 1'b0;
                action     = tdthk_pkg::ACT_TAP;
            end
        end
        else if (!item.is_dual_key)
        begin
            // another key: press forces hold, or flushes a pending tap
            if (item.pressed)
            begin
                if (phase_reg == tdthk_pkg::PH_PRESSED && !hold_reg)
                begin
                    hold_next = 1'b1;
                    action    = tdthk_pkg::ACT_HOLD_ON;
                end
                else if (phase_reg == tdthk_pkg::PH_WAIT)
                begin
                    phase_next = tdthk_pkg::PH_IDLE;
                    kana_next  = 1'b0;
                    action     = tdthk_pkg::ACT_TAP;
                end
            end
        end
        else
        begin
            consumed = 1'b1;
            if (item.pressed)
            begin
                if (phase_reg == tdthk_pkg::PH_WAIT)
                begin
                    phase_next = tdthk_pkg::PH_IDLE;
                    kana_next  = 1'b1;
                    action     = tdthk_pkg::ACT_DOUBLE;
                end
                else
                begin
                    // also a repeated press: restart count, keep hold flag
                    phase_next   = tdthk_pkg::PH_PRESSED;
                    elapsed_next = '0;
                end
            end
            else if (phase_reg == tdthk_pkg::PH_PRESSED)
            begin
                if (hold_reg)
                begin
                    hold_next  = 1'b0;
                    phase_next = tdthk_pkg::PH_IDLE;
                    action     = tdthk_pkg::ACT_HOLD_OFF;
                end
                else
                begin
                    phase_next   = tdthk_pkg::PH_WAIT;
                    elapsed_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tdthk_pkg::PH_IDLE;
            hold_reg    <= 1'b0;
            elapsed_reg <= '0;
            kana_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            hold_reg    <= hold_next;
            elapsed_reg <= elapsed_next;
            kana_reg    <= kana_next;
        end
    end

    assign result.action       = action;
    assign result.consumed     = consumed;
    assign result.hold_active  = hold_next;
    assign result.base_is_kana = kana_next;

    `TDTHK_ASSERT(a_phase_onehot, clk, rst_n, $onehot(phase_reg))
    `TDTHK_NEVER(a_hold_outside_press, clk, rst_n,
        hold_reg && phase_reg != tdthk_pkg::PH_PRESSED)
    `TDTHK_ASSERT(a_tap_clears_kana, clk, rst_n,
        fire && action == tdthk_pkg::ACT_TAP |=> !kana_reg && phase_reg == tdthk_pkg::PH_IDLE)
    `TDTHK_ASSERT(a_double_sets_kana, clk, rst_n,
        fire && action == tdthk_pkg::ACT_DOUBLE |=> kana_reg && !hold_reg)

endmodule

`default_nettype wire

/* rtl/core/tdthk_out_stage.sv */
// Result register: holds one result transaction until the receiver takes it.
// Depends on tdthk_pkg.
`default_nettype none

module tdthk_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire tdthk_pkg::result_t result,
    output logic                    advance,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output tdthk_pkg::result_t      m_result
);

    logic               out_valid_reg;
    tdthk_pkg::result_t result_reg;

    // register may load when empty or when its content leaves this cycle
    assign advance = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

/* rtl/core/tap_double_tap_hold_key_detector_top.sv */
// Top level of the tap / double tap / hold key detector.
// Depends on tdthk_pkg, tdthk_cfg_regs, tdthk_in_stage, tdthk_fsm, tdthk_out_stage.
//
// Usage:
//   Slave stream s_*: one transaction per item. s_tuser = mode (0 = 1 ms tick,
//   1 = key event); s_tdata carries the key event fields.
//   Master stream m_*: exactly one result transaction per input transaction,
//   in order, carrying the action code and the status flags after the item.
//   Config port: cfg_wen/cfg_addr/cfg_wdata write hold term (index 0) and
//   double tap term (index 1); write only while no transaction is in flight.
// An accepted item goes into the input register, then through the classifier
//   logic into the result register, which drives m_tvalid.
// Throughput: one transaction per cycle while m_tready stays high; the classifier
//   state update is combinational logic between input and result registers.
// Reset: state to idle, hold off, counter zero, alphanumeric base; terms to
//   200 and 180; both pipeline registers empty.
// Stall: while m_tready is low a pending result holds; the input register
//   still takes one more transaction, then s_tready drops until room appears.
`default_nettype none

module tap_double_tap_hold_key_detector_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] is_dual_key, [1] pressed, [7:2] zero
    input  wire logic        s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [2:0] action, [3] consumed, [4] hold_active,
                                        // [5] base_is_kana, [7:6] zero
    input  wire logic        cfg_wen,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    tdthk_pkg::item_t             s_item;
    tdthk_pkg::item_t             in_item;
    tdthk_pkg::result_t           result;
    tdthk_pkg::result_t           m_result;
    logic                         in_valid;
    logic                         advance;
    logic                         fire;
    logic [tdthk_pkg::TERM_W-1:0] hold_term;
    logic [tdthk_pkg::TERM_W-1:0] dtap_term;

    assign s_item.mode        = s_tuser;
    assign s_item.is_dual_key = s_tdata[0];
    assign s_item.pressed     = s_tdata[1];

    // state commits when the input register hands its item to the result register
    assign fire = in_valid && advance;

    tdthk_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (tdthk_pkg::cfg_idx_t'(cfg_addr)),
        .cfg_wdata (cfg_wdata),
        .hold_term (hold_term),
        .dtap_term (dtap_term)
    );

    tdthk_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    tdthk_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item),
        .hold_term (hold_term),
        .dtap_term (dtap_term),
        .result    (result)
    );

    tdthk_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {2'b00, m_result};

endmodule

`default_nettype wire
